// ===== rtl/core/bytecode_stack_depth_verifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// Bytecode stack depth verifier: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTECODE_STACK_DEPTH_VERIFIER_CORE_DEFINES_SVH
`define BYTECODE_STACK_DEPTH_VERIFIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BSDV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSDV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsdv_pkg.sv =====
// ----------------------------------------------------------------------------
// Bytecode stack depth verifier package
// Opcodes, status codes, decoder result type and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdv_pkg;

    localparam int CODE_DEPTH_DEF   = 4096;
    localparam int STACK_LIMIT_DEF  = 256;
    localparam int GLOBAL_LIMIT_DEF = 256;
    localparam int MAX_NARGS        = 16;
    localparam int POP_W            = 17;
    localparam int LEN_W            = 3;

    localparam logic [7:0] OP_NOP          = 8'h00;
    localparam logic [7:0] OP_HALT         = 8'h01;
    localparam logic [7:0] OP_PUSH_CONST   = 8'h02;
    localparam logic [7:0] OP_POP          = 8'h03;
    localparam logic [7:0] OP_PUSH_BYTE    = 8'h04;
    localparam logic [7:0] OP_POP_BYTE     = 8'h05;
    localparam logic [7:0] OP_LOAD_GLOBAL  = 8'h06;
    localparam logic [7:0] OP_STORE_GLOBAL = 8'h07;
    localparam logic [7:0] OP_ALU_FIRST    = 8'h10;
    localparam logic [7:0] OP_ALU_LAST     = 8'h1C;
    localparam logic [7:0] OP_DISCARD      = 8'h20;
    localparam logic [7:0] OP_JMP          = 8'h30;
    localparam logic [7:0] OP_JMP_COND     = 8'h31;
    localparam logic [7:0] OP_CALL         = 8'h38;
    localparam logic [7:0] OP_RET          = 8'h39;
    localparam logic [7:0] OP_CALL_NATIVE  = 8'h3A;
    localparam logic [7:0] OP_CALL_NATIVE2 = 8'h3B;
    localparam logic [7:0] OP_MAKE_LIST    = 8'h40;
    localparam logic [7:0] OP_MAKE_MAP     = 8'h41;
    localparam logic [7:0] OP_INDEX        = 8'h42;
    localparam logic [7:0] OP_STORE_INDEX  = 8'h43;

    typedef enum logic [4:0] {
        ST_OK         = 5'd0,
        ST_EMPTY      = 5'd1,
        ST_PC_BOUNDS  = 5'd2,
        ST_NEG_DEPTH  = 5'd3,
        ST_DEPTH_OVER = 5'd4,
        ST_JOIN       = 5'd5,
        ST_TRUNC_OPND = 5'd6,
        ST_CONST_IDX  = 5'd7,
        ST_GLOBAL_IDX = 5'd8,
        ST_CALL_ADDR  = 5'd9,
        ST_NARGS      = 5'd10,
        ST_UNKNOWN_OP = 5'd11,
        ST_TRUNC_INSN = 5'd12,
        ST_UNDERFLOW  = 5'd13,
        ST_NEXT_DEPTH = 5'd14,
        ST_JUMP       = 5'd15,
        ST_TOO_LONG   = 5'd16
    } status_t;

    typedef struct packed {
        logic             err;
        status_t          status;
        logic [LEN_W-1:0] len;
        logic [POP_W-1:0] pop;
        logic             push;
        logic             dom_en;
        logic [5:0]       dom_idx;
    } dec_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsdv_decode.sv =====
// ----------------------------------------------------------------------------
// Bytecode stack depth verifier: opcode decoder
// Gives length, pops, pushes, operand checks and domain use of one opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdv_decode #(
    parameter int AW           = 12,
    parameter int GLOBAL_LIMIT = 256
) (
    input  wire logic [7:0]    op_byte,
    input  wire logic [7:0]    b1,
    input  wire logic [7:0]    b2,
    input  wire logic [7:0]    b3,
    input  wire logic [7:0]    b4,
    input  wire logic [AW-1:0] pc,
    input  wire logic [AW:0]   n,
    input  wire logic [15:0]   const_limit,
    output bsdv_pkg::dec_t     dec
);
    import bsdv_pkg::*;

    logic [15:0] rd16;
    logic [AW:0] end3;
    logic [AW:0] end4;
    logic [AW:0] end5;
    logic        tr3;
    logic        tr4;
    logic        tr5;

    assign rd16 = {b2, b1};
    assign end3 = {1'b0, pc} + (AW+1)'(3);
    assign end4 = {1'b0, pc} + (AW+1)'(4);
    assign end5 = {1'b0, pc} + (AW+1)'(5);
    assign tr3  = end3 > n;
    assign tr4  = end4 > n;
    assign tr5  = end5 > n;

    always_comb
    begin
        dec         = '0;
        dec.status  = ST_OK;
        dec.len     = LEN_W'(1);
        case (op_byte) inside
            OP_NOP, OP_HALT:
            begin
                dec.len = LEN_W'(1);
            end
            OP_PUSH_CONST:
            begin
                dec.len  = LEN_W'(3);
                dec.push = 1'b1;
                if (tr3)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_OPND;
                end
                else if (rd16 >= const_limit)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_CONST_IDX;
                end
            end
            OP_POP, OP_DISCARD, OP_RET:
            begin
                dec.pop = POP_W'(1);
            end
            OP_PUSH_BYTE:
            begin
                dec.len  = LEN_W'(2);
                dec.push = 1'b1;
            end
            OP_POP_BYTE:
            begin
                dec.len = LEN_W'(2);
                dec.pop = POP_W'(1);
            end
            OP_LOAD_GLOBAL, OP_STORE_GLOBAL:
            begin
                dec.len  = LEN_W'(3);
                dec.push = (op_byte == OP_LOAD_GLOBAL);
                dec.pop  = POP_W'(op_byte == OP_STORE_GLOBAL);
                if (tr3)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_OPND;
                end
                else if ({1'b0, rd16} >= 17'(GLOBAL_LIMIT))
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_GLOBAL_IDX;
                end
            end
            [OP_ALU_FIRST:OP_ALU_LAST], OP_INDEX:
            begin
                dec.pop  = POP_W'(2);
                dec.push = 1'b1;
            end
            OP_JMP:
            begin
                dec.len = LEN_W'(3);
            end
            OP_JMP_COND:
            begin
                dec.len = LEN_W'(3);
                dec.pop = POP_W'(1);
            end
            OP_CALL, OP_CALL_NATIVE:
            begin
                dec.len  = LEN_W'(4);
                dec.pop  = POP_W'(b3);
                dec.push = 1'b1;
                if (tr3)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_OPND;
                end
                else if (op_byte == OP_CALL && {1'b0, rd16} >= 17'(n))
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_CALL_ADDR;
                end
                else if (tr4)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_INSN;
                end
                else if (b3 > 8'(MAX_NARGS))
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_NARGS;
                end
                else if (op_byte == OP_CALL_NATIVE)
                begin
                    dec.dom_en  = 1'b1;
                    dec.dom_idx = (rd16 == 16'd0 || rd16 == 16'd1 || rd16 == 16'd17 ||
                                   rd16 == 16'd18) ? 6'd1 : 6'd0;
                end
            end
            OP_CALL_NATIVE2:
            begin
                dec.len  = LEN_W'(5);
                dec.pop  = POP_W'(b4);
                dec.push = 1'b1;
                if (tr5)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_OPND;
                end
                else if (b4 > 8'(MAX_NARGS))
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_NARGS;
                end
                else
                begin
                    dec.dom_en  = 1'b1;
                    dec.dom_idx = b1[5:0];
                end
            end
            OP_MAKE_LIST, OP_MAKE_MAP:
            begin
                dec.len  = LEN_W'(3);
                dec.push = 1'b1;
                dec.pop  = (op_byte == OP_MAKE_MAP) ? {rd16, 1'b0} : {1'b0, rd16};
                if (tr3)
                begin
                    dec.err    = 1'b1;
                    dec.status = ST_TRUNC_OPND;
                end
            end
            OP_STORE_INDEX:
            begin
                dec.pop = POP_W'(3);
            end
            default:
            begin
                dec.err    = 1'b1;
                dec.status = ST_UNKNOWN_OP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bytecode_stack_depth_verifier_core.sv =====
// ----------------------------------------------------------------------------
// Bytecode stack depth verifier core
// Loads a program byte by byte, then walks it breadth-first checking depths.
// ----------------------------------------------------------------------------
// Usage:
// Program bytes arrive on the s_ channel, one word per cycle, code_byte in
// s_tdata, the final byte marked by s_tlast. A word with s_tuser set carries
// no byte, drops any partial program and yields an "empty" result at once.
// The word with s_tlast starts the walk; s_tready stays low until the result
// is placed in the output register. The walk runs from address 0 using a work
// queue in memory. An expanded entry passes S_POP, S_ENT, S_VIS, S_FETCH,
// S_DEC, S_CHK and S_ENQ1, plus S_ENQ2 when it queues two successors; a halt
// or a return ends after S_CHK, and a join to an address already seen after
// S_VIS. The single code read port fetches opcode and four operand bytes.
// Each program gives one m_ word with status, failing pc, failing opcode and
// the domain mask. The output register holds a result until m_tready, and
// s_tready stays low while a result waits there, so loading resumes only once
// the receiver takes it.
// Reset clears the control state and const_limit; memories need no clearing,
// because each loaded byte clears the visited flag of its own address.
// ----------------------------------------------------------------------------
`default_nettype none

module bytecode_stack_depth_verifier_core #(
    parameter int CODE_DEPTH   = bsdv_pkg::CODE_DEPTH_DEF,
    parameter int STACK_LIMIT  = bsdv_pkg::STACK_LIMIT_DEF,
    parameter int GLOBAL_LIMIT = bsdv_pkg::GLOBAL_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] code_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        s_tuser,   // is_empty
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata    // [4:0] status, [16:5] failing_pc,
                                        // [24:17] failing_opcode, [88:25] domains_mask
);
    import bsdv_pkg::*;

`include "bytecode_stack_depth_verifier_core_defines.svh"

    localparam int AW  = $clog2(CODE_DEPTH);
    localparam int NW  = AW + 1;
    localparam int QD  = 2 * CODE_DEPTH;
    localparam int QPW = AW + 2;
    localparam int DW  = $clog2(STACK_LIMIT + 1);
    localparam int CW  = (DW > POP_W) ? DW : POP_W;
    localparam int TW  = ((AW + 2 > 17) ? AW + 2 : 17) + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_ENT, S_VIS, S_FETCH, S_DEC, S_CHK, S_ENQ1, S_ENQ2, S_DONE
    } state_t;

    state_t             state_reg;
    logic [15:0]        const_limit_reg;
    logic [NW-1:0]      byte_cnt_reg;
    logic [NW-1:0]      n_reg;
    logic [QPW-1:0]     head_reg;
    logic [QPW-1:0]     tail_reg;
    logic [AW-1:0]      pc_reg;
    logic [DW-1:0]      depth_reg;
    logic [DW-1:0]      next_reg;
    logic [NW-1:0]      after_reg;
    logic [7:0]         op_reg;
    logic [7:0]         opnd_reg [4];
    logic [1:0]         fcnt_reg;
    dec_t               dec_reg;
    logic [63:0]        dom_reg;
    status_t            res_status_reg;
    logic [AW-1:0]      res_pc_reg;
    logic [7:0]         res_op_reg;
    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;

    logic [7:0]         code_mem [CODE_DEPTH];
    logic [DW:0]        dm_mem   [CODE_DEPTH];
    logic [AW+DW-1:0]   q_mem    [QD];
    logic [7:0]         code_rdata_reg;
    logic [DW:0]        dm_rdata_reg;
    logic [AW+DW-1:0]   q_rdata_reg;

    logic               code_we;
    logic [AW-1:0]      code_raddr;
    logic               dm_we;
    logic [AW-1:0]      dm_waddr;
    logic [DW:0]        dm_wdata;
    logic [AW-1:0]      dm_raddr;
    logic               q_we;
    logic [AW:0]        q_waddr;
    logic [AW+DW-1:0]   q_wdata;

    logic               accept_in;
    logic               room;
    logic               cfg_wr;
    logic               res_set;
    logic [AW-1:0]      q_pc;
    logic [DW-1:0]      q_depth;
    logic [15:0]        rd16;
    logic               start_walk;
    logic               store_byte;
    logic               after_in;
    logic [NW-1:0]      end_len;
    logic               underflow;
    logic [DW:0]        next_w;
    logic signed [TW-1:0] target;
    logic               target_bad;
    dec_t               dec;

    assign pready     = 1'b1;
    assign prdata     = (paddr == 2'd0) ? {16'd0, const_limit_reg} : 32'd0;
    assign cfg_wr     = psel && penable && pwrite && (paddr == 2'd0);
    assign room       = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == S_LOAD) && room;
    assign accept_in  = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign store_byte = accept_in && !s_tuser && (byte_cnt_reg < NW'(CODE_DEPTH));
    assign start_walk = store_byte && s_tlast;
    assign res_set    = (accept_in && (s_tuser || (!store_byte && s_tlast))) ||
                        ((state_reg == S_DONE) && room);
    assign q_pc       = q_rdata_reg[AW-1:0];
    assign q_depth    = q_rdata_reg[AW+DW-1:AW];
    assign rd16       = {opnd_reg[1], opnd_reg[0]};
    assign after_in   = after_reg < n_reg;
    assign end_len    = {1'b0, pc_reg} + NW'(dec_reg.len);
    assign underflow  = CW'(depth_reg) < CW'(dec_reg.pop);
    assign next_w     = (DW+1)'(depth_reg) - (DW+1)'(dec_reg.pop) + (DW+1)'(dec_reg.push);
    assign target     = $signed({{(TW-NW){1'b0}}, after_reg}) +
                        $signed({{(TW-16){rd16[15]}}, rd16});
    assign target_bad = (target < 0) || (target >= $signed({{(TW-NW){1'b0}}, n_reg}));

    bsdv_decode #(
        .AW           (AW),
        .GLOBAL_LIMIT (GLOBAL_LIMIT)
    ) u_decode (
        .op_byte     (op_reg),
        .b1          (opnd_reg[0]),
        .b2          (opnd_reg[1]),
        .b3          (opnd_reg[2]),
        .b4          (opnd_reg[3]),
        .pc          (pc_reg),
        .n           (n_reg),
        .const_limit (const_limit_reg),
        .dec         (dec)
    );

    always_comb
    begin
        code_we    = 1'b0;
        code_raddr = pc_reg;
        dm_we      = 1'b0;
        dm_waddr   = byte_cnt_reg[AW-1:0];
        dm_wdata   = '0;
        dm_raddr   = q_pc;
        q_we       = 1'b0;
        q_waddr    = tail_reg[AW:0];
        q_wdata    = {next_reg, after_reg[AW-1:0]};
        case (state_reg)
            S_LOAD:
            begin
                code_we = store_byte;
                dm_we   = store_byte;
                if (start_walk)
                begin
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = '0;
                end
            end
            S_ENT:
            begin
                code_raddr = q_pc;
            end
            S_VIS:
            begin
                code_raddr = pc_reg + AW'(1);
                if (!dm_rdata_reg[DW] && !((DW+1)'(depth_reg) > (DW+1)'(STACK_LIMIT)))
                begin
                    dm_we    = 1'b1;
                    dm_waddr = pc_reg;
                    dm_wdata = {1'b1, depth_reg};
                end
            end
            S_FETCH:
            begin
                code_raddr = pc_reg + AW'(2) + AW'(fcnt_reg);
            end
            S_ENQ1:
            begin
                if (op_reg == OP_JMP || op_reg == OP_JMP_COND)
                begin
                    q_we    = !target_bad;
                    q_wdata = {next_reg, target[AW-1:0]};
                end
                else if (op_reg == OP_CALL)
                begin
                    q_we    = 1'b1;
                    q_wdata = {depth_reg, rd16[AW-1:0]};
                end
                else
                begin
                    q_we = after_in;
                end
            end
            S_ENQ2:
            begin
                q_we = 1'b1;
            end
            default:
            begin
                q_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[byte_cnt_reg[AW-1:0]] <= s_tdata;
        end
        code_rdata_reg <= code_mem[code_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        dm_rdata_reg <= dm_mem[dm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[head_reg[AW:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
        begin
            opnd_reg[fcnt_reg] <= code_rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            const_limit_reg <= '0;
            byte_cnt_reg    <= '0;
            n_reg           <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            dom_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            fcnt_reg        <= '0;
            pc_reg          <= '0;
            depth_reg       <= '0;
            next_reg        <= '0;
            after_reg       <= '0;
            op_reg          <= '0;
            dec_reg         <= '0;
            res_status_reg  <= ST_OK;
            res_pc_reg      <= '0;
            res_op_reg      <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                const_limit_reg <= pwdata[15:0];
            end
            m_tvalid_reg <= res_set || (m_tvalid_reg && !m_tready);
            if (q_we && state_reg != S_LOAD)
            begin
                tail_reg <= tail_reg + QPW'(1);
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (accept_in)
                    begin
                        if (s_tuser)
                        begin
                            byte_cnt_reg <= '0;
                            m_tdata_reg  <= {91'd0, ST_EMPTY};
                        end
                        else if (store_byte)
                        begin
                            byte_cnt_reg <= s_tlast ? '0 : byte_cnt_reg + NW'(1);
                            if (s_tlast)
                            begin
                                n_reg     <= byte_cnt_reg + NW'(1);
                                head_reg  <= '0;
                                tail_reg  <= QPW'(1);
                                dom_reg   <= '0;
                                state_reg <= S_POP;
                            end
                        end
                        else if (s_tlast)
                        begin
                            byte_cnt_reg <= '0;
                            m_tdata_reg  <= {91'd0, ST_TOO_LONG};
                        end
                        else
                        begin
                            byte_cnt_reg <= NW'(CODE_DEPTH + 1);
                        end
                    end
                end
                S_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        res_status_reg <= ST_OK;
                        res_pc_reg     <= '0;
                        res_op_reg     <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        head_reg  <= head_reg + QPW'(1);
                        state_reg <= S_ENT;
                    end
                end
                S_ENT:
                begin
                    pc_reg    <= q_pc;
                    depth_reg <= q_depth;
                    if ({1'b0, q_pc} >= n_reg)
                    begin
                        res_status_reg <= ST_PC_BOUNDS;
                        res_pc_reg     <= q_pc;
                        res_op_reg     <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_VIS;
                    end
                end
                S_VIS:
                begin
                    op_reg     <= code_rdata_reg;
                    res_pc_reg <= pc_reg;
                    res_op_reg <= code_rdata_reg;
                    fcnt_reg   <= '0;
                    if ((DW+1)'(depth_reg) > (DW+1)'(STACK_LIMIT))
                    begin
                        res_status_reg <= ST_DEPTH_OVER;
                        state_reg      <= S_DONE;
                    end
                    else if (dm_rdata_reg[DW])
                    begin
                        if (dm_rdata_reg[DW-1:0] != depth_reg)
                        begin
                            res_status_reg <= ST_JOIN;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    fcnt_reg <= fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    dec_reg <= dec;
                    if (dec.err)
                    begin
                        res_status_reg <= dec.status;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (dec.dom_en)
                        begin
                            dom_reg <= dom_reg | (64'd1 << dec.dom_idx);
                        end
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    next_reg  <= next_w[DW-1:0];
                    after_reg <= end_len;
                    if (end_len > n_reg)
                    begin
                        res_status_reg <= ST_TRUNC_INSN;
                        state_reg      <= S_DONE;
                    end
                    else if (underflow)
                    begin
                        res_status_reg <= ST_UNDERFLOW;
                        state_reg      <= S_DONE;
                    end
                    else if (next_w > (DW+1)'(STACK_LIMIT))
                    begin
                        res_status_reg <= ST_NEXT_DEPTH;
                        state_reg      <= S_DONE;
                    end
                    else if (op_reg == OP_HALT || op_reg == OP_RET)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_ENQ1;
                    end
                end
                S_ENQ1:
                begin
                    if ((op_reg == OP_JMP || op_reg == OP_JMP_COND) && target_bad)
                    begin
                        res_status_reg <= ST_JUMP;
                        state_reg      <= S_DONE;
                    end
                    else if ((op_reg == OP_JMP_COND || op_reg == OP_CALL) && after_in)
                    begin
                        state_reg <= S_ENQ2;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_ENQ2:
                begin
                    state_reg <= S_POP;
                end
                S_DONE:
                begin
                    if (room)
                    begin
                        m_tdata_reg  <= {7'd0,
                                         (res_status_reg == ST_OK) ? dom_reg : 64'd0,
                                         res_op_reg, 12'(res_pc_reg), res_status_reg};
                        state_reg    <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `BSDV_ASSERT_IMP(a_busy_not_ready, state_reg != S_LOAD, !s_tready,
        "Input accepted while a walk is in progress.")
    `BSDV_ASSERT_IMP(a_queue_bound, 1'b1, (tail_reg - head_reg) <= QPW'(QD),
        "Work queue holds more entries than its depth.")
    `BSDV_ASSERT_NXT(a_walk_starts, start_walk, state_reg == S_POP,
        "Last byte of a program did not start the walk.")
    `BSDV_ASSERT_IMP(a_ok_clean, m_tvalid && m_tdata[4:0] == ST_OK, m_tdata[24:5] == 20'd0,
        "Passing result carries a failing pc or opcode.")

endmodule

`default_nettype wire
